// File: sv/owb_pkg.sv
// Shared types and constants for the single-wire bus master.
// Used by the register file, the slot engine, the top level and the testbench.
package owb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int US_W       = 10;

    // Operation codes carried by a command word.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_MIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_MAX      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_ZERO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_DELAY    = 3'd5;

    // Register reset values.
    localparam logic [9:0] RST_RESET_LOW  = 10'd600;
    localparam logic [9:0] RST_PRES_WAIT  = 10'd200;
    localparam logic [9:0] RST_PRES_MIN   = 10'd60;
    localparam logic [9:0] RST_PRES_MAX   = 10'd240;
    localparam logic [6:0] RST_WRITE_ZERO = 7'd80;
    localparam logic [3:0] RST_READ_DELAY = 4'd5;

    // Fixed slot timing in microseconds.
    localparam logic [US_W-1:0] RESET_RELEASE_US   = 10'd60;
    localparam logic [US_W-1:0] PRESENCE_LOW_LIMIT = 10'd300;
    localparam logic [US_W-1:0] WRITE_GAP_US       = 10'd3;
    localparam logic [US_W-1:0] WRITE_ONE_LOW_US   = 10'd3;
    localparam logic [US_W-1:0] WRITE_ONE_REL_US   = 10'd63;
    localparam logic [US_W-1:0] READ_GAP_US        = 10'd2;
    localparam logic [US_W-1:0] READ_LOW_US        = 10'd3;
    localparam logic [US_W-1:0] READ_RECOVER_US    = 10'd65;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_REL  = 4'd2,
        PH_RST_WAIT = 4'd3,
        PH_RST_MEAS = 4'd4,
        PH_W_GAP    = 4'd5,
        PH_W_LOW    = 4'd6,
        PH_W_REL    = 4'd7,
        PH_R_GAP    = 4'd8,
        PH_R_LOW    = 4'd9,
        PH_R_DELAY  = 4'd10,
        PH_R_REC    = 4'd11
    } t_phase;

    typedef struct packed {
        logic [9:0] reset_low_time;
        logic [9:0] presence_wait_limit;
        logic [9:0] presence_min;
        logic [9:0] presence_max;
        logic [6:0] write_zero_low;
        logic [3:0] read_sample_delay;
    } t_cfg;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       line_level;
    } t_cmd;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_byte;
        logic       rejected;
    } t_res;

endpackage

// File: sv/owb_cmd_if.sv
// Command channel: one word per microsecond tick with operation, data and line level.
// Depends on nothing else.
interface owb_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] data_byte;
    logic       line_level;

    modport source (output valid, output operation, output data_byte, output line_level,
                    input ready);
    modport sink   (input valid, input operation, input data_byte, input line_level,
                    output ready);
endinterface

// File: sv/owb_res_if.sv
// Result channel: line drive and status, one word per command word.
// Depends on nothing else.
interface owb_res_if;
    logic       valid;
    logic       ready;
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_byte;
    logic       rejected;

    modport source (output valid, output drive_low, output busy_res, output done_res,
                    output presence, output read_byte, output rejected, input ready);
    modport sink   (input valid, input drive_low, input busy_res, input done_res,
                    input presence, input read_byte, input rejected, output ready);
endinterface

// File: sv/one_wire_bus_master.sv
// Single-wire bus master top level: command register, slot engine, result register; needs
// owb_pkg, owb_cmd_if, owb_res_if, owb_cfg_regs and owb_engine.
// The command word is registered, then stepped into the result register once that register is free.
// Throughput: one word per cycle; input stalls only while both registers hold a word.
// Synchronous active-low reset empties both registers, idles the engine and loads the
// default timing register values.
module one_wire_bus_master (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    owb_cmd_if.sink                         i_cmd,
    owb_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [owb_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    owb_pkg::t_cfg cfg;
    owb_pkg::t_cmd r_cmd;
    logic          r_cmd_valid;
    owb_pkg::t_res r_res;
    logic          r_res_valid;
    owb_pkg::t_res step_res;
    logic          step;
    logic          cmd_take;

    assign step     = r_cmd_valid && (!r_res_valid || o_res.ready);
    assign cmd_take = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_cmd_valid || step;

    owb_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    owb_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cmd   (r_cmd),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (cmd_take) begin
                r_cmd_valid <= 1'b1;
            end else if (step) begin
                r_cmd_valid <= 1'b0;
            end
            if (step) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take) begin
            r_cmd.operation  <= i_cmd.operation;
            r_cmd.data_byte  <= i_cmd.data_byte;
            r_cmd.line_level <= i_cmd.line_level;
        end
        if (step) begin
            r_res <= step_res;
        end
    end

    assign o_res.valid     = r_res_valid;
    assign o_res.drive_low = r_res.drive_low;
    assign o_res.busy_res  = r_res.busy_res;
    assign o_res.done_res  = r_res.done_res;
    assign o_res.presence  = r_res.presence;
    assign o_res.read_byte = r_res.read_byte;
    assign o_res.rejected  = r_res.rejected;

endmodule

// File: sv/owb_cfg_regs.sv
// Timing configuration registers of the single-wire bus master.
// Depends on owb_pkg.
module owb_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [owb_pkg::CFG_IDX_W-1:0]       i_idx,
    input  logic [owb_pkg::CFG_DATA_W-1:0]      i_wdata,
    output owb_pkg::t_cfg                       o_cfg
);

    owb_pkg::t_cfg r_cfg;
    owb_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_idx)
                owb_pkg::CFG_RESET_LOW:  n_cfg.reset_low_time      = i_wdata[9:0];
                owb_pkg::CFG_PRES_WAIT:  n_cfg.presence_wait_limit = i_wdata[9:0];
                owb_pkg::CFG_PRES_MIN:   n_cfg.presence_min        = i_wdata[9:0];
                owb_pkg::CFG_PRES_MAX:   n_cfg.presence_max        = i_wdata[9:0];
                owb_pkg::CFG_WRITE_ZERO: n_cfg.write_zero_low      = i_wdata[6:0];
                owb_pkg::CFG_READ_DELAY: n_cfg.read_sample_delay   = i_wdata[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time      <= owb_pkg::RST_RESET_LOW;
            r_cfg.presence_wait_limit <= owb_pkg::RST_PRES_WAIT;
            r_cfg.presence_min        <= owb_pkg::RST_PRES_MIN;
            r_cfg.presence_max        <= owb_pkg::RST_PRES_MAX;
            r_cfg.write_zero_low      <= owb_pkg::RST_WRITE_ZERO;
            r_cfg.read_sample_delay   <= owb_pkg::RST_READ_DELAY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/owb_engine.sv
// Slot engine: phase, microsecond counter, bit index and shift register of the bus master.
// Computes one result word per step from the registered command word. Depends on owb_pkg.
module owb_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_step,
    input  owb_pkg::t_cmd  i_cmd,
    input  owb_pkg::t_cfg  i_cfg,
    output owb_pkg::t_res  o_res
);

    owb_pkg::t_phase r_phase, n_phase;
    logic [9:0]      r_count, n_count;
    logic [2:0]      r_bit_idx, n_bit_idx;
    logic [7:0]      r_shift, n_shift;
    logic            r_presence, n_presence;
    logic [7:0]      r_last_read, n_last_read;

    // State as seen by this word once a command from idle has been started.
    owb_pkg::t_phase eff_phase;
    logic [9:0]      eff_count;
    logic [2:0]      eff_bit;
    logic [7:0]      eff_shift;
    logic            rej;

    logic [9:0]      cnt_inc;
    logic [7:0]      sample_shift;
    logic [9:0]      meas;
    logic            last_bit;

    logic            drive;
    logic            bit_end;
    logic            done;

    always_comb begin
        eff_phase = r_phase;
        eff_count = r_count;
        eff_bit   = r_bit_idx;
        eff_shift = r_shift;
        rej       = 1'b0;
        if (r_phase != owb_pkg::PH_IDLE) begin
            rej = (i_cmd.operation != owb_pkg::OP_TICK);
        end else begin
            eff_count = '0;
            eff_bit   = '0;
            unique case (i_cmd.operation)
                owb_pkg::OP_TICK:  eff_phase = owb_pkg::PH_IDLE;
                owb_pkg::OP_RESET: eff_phase = owb_pkg::PH_RST_LOW;
                owb_pkg::OP_WRITE: begin
                    eff_phase = owb_pkg::PH_W_GAP;
                    eff_shift = i_cmd.data_byte;
                end
                owb_pkg::OP_READ: begin
                    eff_phase = owb_pkg::PH_R_GAP;
                    eff_shift = '0;
                end
                default: eff_phase = owb_pkg::PH_IDLE;
            endcase
        end
    end

    assign cnt_inc      = eff_count + 10'd1;
    assign last_bit     = (eff_bit == owb_pkg::LAST_BIT);
    // The read bit is taken on the first microsecond of the recovery time.
    assign sample_shift = (eff_count == '0) ? {i_cmd.line_level, eff_shift[7:1]} : eff_shift;
    // A presence pulse that ends on a high sample is measured without this microsecond.
    assign meas         = i_cmd.line_level ? eff_count : cnt_inc;

    // Output decode: line drive, end of a write bit and completion of the operation.
    always_comb begin
        drive   = 1'b0;
        bit_end = 1'b0;
        done    = 1'b0;
        unique case (eff_phase)
            owb_pkg::PH_RST_LOW: drive = 1'b1;
            owb_pkg::PH_RST_WAIT:
                done = i_cmd.line_level && (cnt_inc >= i_cfg.presence_wait_limit);
            owb_pkg::PH_RST_MEAS:
                done = i_cmd.line_level || (cnt_inc >= owb_pkg::PRESENCE_LOW_LIMIT);
            owb_pkg::PH_W_LOW: begin
                drive   = 1'b1;
                bit_end = !eff_shift[0] && (cnt_inc >= {3'b000, i_cfg.write_zero_low});
                done    = bit_end && last_bit;
            end
            owb_pkg::PH_W_REL: begin
                bit_end = (cnt_inc >= owb_pkg::WRITE_ONE_REL_US);
                done    = bit_end && last_bit;
            end
            owb_pkg::PH_R_LOW: drive = 1'b1;
            owb_pkg::PH_R_REC:
                done = (cnt_inc >= owb_pkg::READ_RECOVER_US) && last_bit;
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        n_phase     = eff_phase;
        n_count     = cnt_inc;
        n_bit_idx   = eff_bit;
        n_shift     = eff_shift;
        n_presence  = r_presence;
        n_last_read = r_last_read;
        unique case (eff_phase)
            owb_pkg::PH_IDLE: n_count = '0;
            owb_pkg::PH_RST_LOW:
                if (cnt_inc >= i_cfg.reset_low_time) begin
                    n_phase = owb_pkg::PH_RST_REL;
                    n_count = '0;
                end
            owb_pkg::PH_RST_REL:
                if (cnt_inc >= owb_pkg::RESET_RELEASE_US) begin
                    n_phase = owb_pkg::PH_RST_WAIT;
                    n_count = '0;
                end
            owb_pkg::PH_RST_WAIT:
                if (!i_cmd.line_level) begin
                    n_phase = owb_pkg::PH_RST_MEAS;
                    n_count = 10'd1;
                end else if (done) begin
                    n_presence = 1'b0;
                end
            owb_pkg::PH_RST_MEAS:
                if (done) begin
                    n_presence = (meas >= i_cfg.presence_min) && (meas <= i_cfg.presence_max);
                end
            owb_pkg::PH_W_GAP:
                if (cnt_inc >= owb_pkg::WRITE_GAP_US) begin
                    n_phase = owb_pkg::PH_W_LOW;
                    n_count = '0;
                end
            owb_pkg::PH_W_LOW, owb_pkg::PH_W_REL: begin
                if (eff_phase == owb_pkg::PH_W_LOW && eff_shift[0]
                        && cnt_inc >= owb_pkg::WRITE_ONE_LOW_US) begin
                    n_phase = owb_pkg::PH_W_REL;
                    n_count = '0;
                end
                if (bit_end) begin
                    n_shift = {1'b0, eff_shift[7:1]};
                    if (!last_bit) begin
                        n_bit_idx = eff_bit + 3'd1;
                        n_phase   = owb_pkg::PH_W_GAP;
                        n_count   = '0;
                    end
                end
            end
            owb_pkg::PH_R_GAP:
                if (cnt_inc >= owb_pkg::READ_GAP_US) begin
                    n_phase = owb_pkg::PH_R_LOW;
                    n_count = '0;
                end
            owb_pkg::PH_R_LOW:
                if (cnt_inc >= owb_pkg::READ_LOW_US) begin
                    n_phase = owb_pkg::PH_R_DELAY;
                    n_count = '0;
                end
            owb_pkg::PH_R_DELAY:
                if (cnt_inc >= {6'd0, i_cfg.read_sample_delay}) begin
                    n_phase = owb_pkg::PH_R_REC;
                    n_count = '0;
                end
            owb_pkg::PH_R_REC: begin
                n_shift = sample_shift;
                if (cnt_inc >= owb_pkg::READ_RECOVER_US) begin
                    if (last_bit) begin
                        n_last_read = sample_shift;
                    end else begin
                        n_bit_idx = eff_bit + 3'd1;
                        n_phase   = owb_pkg::PH_R_GAP;
                        n_count   = '0;
                    end
                end
            end
            default: begin
                n_phase   = owb_pkg::PH_IDLE;
                n_count   = '0;
                n_bit_idx = '0;
            end
        endcase
        if (done) begin
            n_phase   = owb_pkg::PH_IDLE;
            n_count   = '0;
            n_bit_idx = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= owb_pkg::PH_IDLE;
            r_count     <= '0;
            r_bit_idx   <= '0;
            r_shift     <= '0;
            r_presence  <= 1'b0;
            r_last_read <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_bit_idx   <= n_bit_idx;
            r_shift     <= n_shift;
            r_presence  <= n_presence;
            r_last_read <= n_last_read;
        end
    end

    always_comb begin
        o_res.drive_low = drive;
        o_res.busy_res  = (n_phase != owb_pkg::PH_IDLE);
        o_res.done_res  = done;
        o_res.presence  = n_presence;
        o_res.read_byte = n_last_read;
        o_res.rejected  = rej;
    end

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == owb_pkg::PH_IDLE |-> (r_count == '0) && (r_bit_idx == '0))
        else $error("idle phase with nonzero counter or bit index");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && done |=> r_phase == owb_pkg::PH_IDLE)
        else $error("completed operation did not return to idle");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && rej |-> r_phase != owb_pkg::PH_IDLE)
        else $error("command rejected while idle");

    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_count) && $stable(r_shift))
        else $error("engine state moved without a step");

endmodule

// File: bench/tb_one_wire_bus_master.sv
`timescale 1ns / 100ps
// Testbench for the single-wire bus master: directed bus sequences, each result word
// checked against a word-by-word predictor of the slot timing.
// Depends on owb_pkg, owb_cmd_if, owb_res_if and one_wire_bus_master.
module tb_one_wire_bus_master;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;

    // How the slave side drives the line outside the presence window.
    typedef enum int { LINE_LOW, LINE_HIGH, LINE_RANDOM } t_line_mode;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           cfg_we;
    logic [owb_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [owb_pkg::CFG_DATA_W-1:0] cfg_wdata;

    owb_cmd_if cmd_if ();
    owb_res_if res_if ();

    one_wire_bus_master i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_if),
        .o_res       (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Predicted bus master state and timing registers.
    owb_pkg::t_cfg            timing;
    owb_pkg::t_phase          bus_phase;
    logic [owb_pkg::US_W-1:0] slot_us;
    logic [2:0]               bit_pos;
    logic [7:0]               shift_byte;
    logic                     presence_found;
    logic [7:0]               last_read_byte;

    owb_pkg::t_res pending_status[$];
    owb_pkg::t_res want;

    int errors         = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int resets_started = 0;
    int writes_started = 0;
    int reads_started  = 0;
    int presences      = 0;
    int timeouts       = 0;
    int rejects        = 0;
    int quiet_cycles   = 0;
    int hold_request   = 0;
    int stall_left     = 0;
    bit idling_on      = 1'b1;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    function automatic owb_pkg::t_cfg make_timing(input int rst_low, input int wait_lim,
                                                  input int pres_min, input int pres_max,
                                                  input int zero_low, input int rd_delay);
        owb_pkg::t_cfg c;
        c.reset_low_time      = 10'(rst_low);
        c.presence_wait_limit = 10'(wait_lim);
        c.presence_min        = 10'(pres_min);
        c.presence_max        = 10'(pres_max);
        c.write_zero_low      = 7'(zero_low);
        c.read_sample_delay   = 4'(rd_delay);
        return c;
    endfunction

    function automatic void enter_phase(input owb_pkg::t_phase p);
        bus_phase = p;
        slot_us   = '0;
    endfunction

    function automatic bit count_to(input logic [owb_pkg::US_W-1:0] lim);
        slot_us = slot_us + 10'd1;
        return slot_us >= lim;
    endfunction

    function automatic void finish_command();
        enter_phase(owb_pkg::PH_IDLE);
        bit_pos = '0;
    endfunction

    // Shifts out the bit just written; returns 1 when the byte is complete.
    function automatic bit advance_write_bit();
        shift_byte = shift_byte >> 1;
        if (bit_pos == owb_pkg::LAST_BIT) begin
            finish_command();
            return 1'b1;
        end
        bit_pos = bit_pos + 3'd1;
        enter_phase(owb_pkg::PH_W_GAP);
        return 1'b0;
    endfunction

    // One microsecond of bus time: returns the status word for this command word.
    function automatic owb_pkg::t_res bus_step(input owb_pkg::t_cmd w);
        owb_pkg::t_res r;
        bit            meas_end;
        r = '0;
        meas_end = 1'b0;
        if (bus_phase != owb_pkg::PH_IDLE) begin
            if (w.operation != owb_pkg::OP_TICK) begin
                r.rejected = 1'b1;
                rejects++;
            end
        end else begin
            unique case (w.operation)
                owb_pkg::OP_TICK: ;
                owb_pkg::OP_RESET: begin
                    enter_phase(owb_pkg::PH_RST_LOW);
                    resets_started++;
                end
                owb_pkg::OP_WRITE: begin
                    enter_phase(owb_pkg::PH_W_GAP);
                    bit_pos    = '0;
                    shift_byte = w.data_byte;
                    writes_started++;
                end
                owb_pkg::OP_READ: begin
                    enter_phase(owb_pkg::PH_R_GAP);
                    bit_pos    = '0;
                    shift_byte = '0;
                    reads_started++;
                end
                default: ;
            endcase
        end

        unique case (bus_phase)
            owb_pkg::PH_IDLE: ;
            owb_pkg::PH_RST_LOW: begin
                r.drive_low = 1'b1;
                if (count_to(timing.reset_low_time)) enter_phase(owb_pkg::PH_RST_REL);
            end
            owb_pkg::PH_RST_REL: begin
                if (count_to(owb_pkg::RESET_RELEASE_US)) enter_phase(owb_pkg::PH_RST_WAIT);
            end
            owb_pkg::PH_RST_WAIT: begin
                if (!w.line_level) begin
                    // The first low sample already counts toward the pulse width.
                    bus_phase = owb_pkg::PH_RST_MEAS;
                    slot_us   = 10'd1;
                end else if (count_to(timing.presence_wait_limit)) begin
                    presence_found = 1'b0;
                    timeouts++;
                    finish_command();
                    r.done_res = 1'b1;
                end
            end
            owb_pkg::PH_RST_MEAS: begin
                if (w.line_level) meas_end = 1'b1;
                else meas_end = count_to(owb_pkg::PRESENCE_LOW_LIMIT);
                if (meas_end) begin
                    presence_found = (slot_us >= timing.presence_min) &&
                                     (slot_us <= timing.presence_max);
                    if (presence_found) presences++;
                    finish_command();
                    r.done_res = 1'b1;
                end
            end
            owb_pkg::PH_W_GAP: begin
                if (count_to(owb_pkg::WRITE_GAP_US)) enter_phase(owb_pkg::PH_W_LOW);
            end
            owb_pkg::PH_W_LOW: begin
                r.drive_low = 1'b1;
                if (shift_byte[0]) begin
                    if (count_to(owb_pkg::WRITE_ONE_LOW_US)) enter_phase(owb_pkg::PH_W_REL);
                end else if (count_to({3'd0, timing.write_zero_low})) begin
                    r.done_res = advance_write_bit();
                end
            end
            owb_pkg::PH_W_REL: begin
                if (count_to(owb_pkg::WRITE_ONE_REL_US)) r.done_res = advance_write_bit();
            end
            owb_pkg::PH_R_GAP: begin
                if (count_to(owb_pkg::READ_GAP_US)) enter_phase(owb_pkg::PH_R_LOW);
            end
            owb_pkg::PH_R_LOW: begin
                r.drive_low = 1'b1;
                if (count_to(owb_pkg::READ_LOW_US)) enter_phase(owb_pkg::PH_R_DELAY);
            end
            owb_pkg::PH_R_DELAY: begin
                if (count_to({6'd0, timing.read_sample_delay})) enter_phase(owb_pkg::PH_R_REC);
            end
            owb_pkg::PH_R_REC: begin
                // The bit is sampled on the first microsecond of the recovery time.
                if (slot_us == '0) shift_byte = {w.line_level, shift_byte[7:1]};
                if (count_to(owb_pkg::READ_RECOVER_US)) begin
                    if (bit_pos == owb_pkg::LAST_BIT) begin
                        last_read_byte = shift_byte;
                        finish_command();
                        r.done_res = 1'b1;
                    end else begin
                        bit_pos = bit_pos + 3'd1;
                        enter_phase(owb_pkg::PH_R_GAP);
                    end
                end
            end
            default: finish_command();
        endcase

        r.busy_res  = (bus_phase != owb_pkg::PH_IDLE);
        r.presence  = presence_found;
        r.read_byte = last_read_byte;
        return r;
    endfunction

    function automatic logic pick_line(input t_line_mode m);
        unique case (m)
            LINE_LOW:    return 1'b0;
            LINE_HIGH:   return 1'b1;
            LINE_RANDOM: return 1'($urandom_range(0, 1));
            default:     return 1'b1;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        errors++;
        $display("MISMATCH at %0t, result word %0d: %s", $time, words_checked, what);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp);
        if (got !== exp) report_mismatch($sformatf("%s is %h, expected %h", name, got, exp));
    endtask

    // Sends one word, with a random gap in front of it when idling is on. It is called at a
    // falling edge and returns at the falling edge after the word was taken.
    task automatic send_word(input owb_pkg::t_cmd w);
        if (idling_on && $urandom_range(0, 11) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.operation  <= w.operation;
        cmd_if.data_byte  <= w.data_byte;
        cmd_if.line_level <= w.line_level;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pending_status.push_back(bus_step(w));
        words_sent++;
        @(negedge i_clk);
    endtask

    // Issues one command and keeps ticking until the master is idle again. During presence
    // detection the slave holds the line high for wait_high samples, then low for low_len.
    task automatic run_command(input logic [1:0] op, input logic [7:0] data,
                               input int wait_high, input int low_len,
                               input t_line_mode mode, input int noise_pct);
        owb_pkg::t_cmd w;
        int            slave_us;
        slave_us     = 0;
        w.operation  = op;
        w.data_byte  = data;
        w.line_level = pick_line(mode);
        send_word(w);
        while (bus_phase != owb_pkg::PH_IDLE) begin
            if ($urandom_range(0, 99) < noise_pct)
                w.operation = 2'($urandom_range(32'(owb_pkg::OP_RESET), 32'(owb_pkg::OP_READ)));
            else
                w.operation = owb_pkg::OP_TICK;
            w.data_byte = 8'($urandom);
            if (bus_phase == owb_pkg::PH_RST_WAIT || bus_phase == owb_pkg::PH_RST_MEAS) begin
                w.line_level = !(slave_us >= wait_high && slave_us < wait_high + low_len);
                slave_us++;
            end else begin
                w.line_level = pick_line(mode);
            end
            send_word(w);
        end
    endtask

    task automatic settle_bus();
        cmd_if.valid <= 1'b0;
        while (pending_status.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_timing(input owb_pkg::t_cfg c);
        settle_bus();
        cfg_we    <= 1'b1;
        cfg_idx   <= owb_pkg::CFG_RESET_LOW;
        cfg_wdata <= c.reset_low_time;
        @(negedge i_clk);
        cfg_idx   <= owb_pkg::CFG_PRES_WAIT;
        cfg_wdata <= c.presence_wait_limit;
        @(negedge i_clk);
        cfg_idx   <= owb_pkg::CFG_PRES_MIN;
        cfg_wdata <= c.presence_min;
        @(negedge i_clk);
        cfg_idx   <= owb_pkg::CFG_PRES_MAX;
        cfg_wdata <= c.presence_max;
        @(negedge i_clk);
        cfg_idx   <= owb_pkg::CFG_WRITE_ZERO;
        cfg_wdata <= {3'd0, c.write_zero_low};
        @(negedge i_clk);
        cfg_idx   <= owb_pkg::CFG_READ_DELAY;
        cfg_wdata <= {6'd0, c.read_sample_delay};
        @(negedge i_clk);
        cfg_we <= 1'b0;
        timing = c;
    endtask

    task automatic test_idle_ticks();
        run_command(owb_pkg::OP_TICK, 8'h00, 0, 0, LINE_LOW, 0);
        run_command(owb_pkg::OP_TICK, 8'hFF, 0, 0, LINE_HIGH, 0);
        run_command(owb_pkg::OP_TICK, 8'h3C, 0, 0, LINE_RANDOM, 0);
    endtask

    // Short timing: wait limit 10, presence accepted from 5 to 40 low samples.
    task automatic test_reset_presence();
        write_timing(make_timing(2, 10, 5, 40, 4, 2));
        run_command(owb_pkg::OP_RESET, 8'h00, 3, 10, LINE_RANDOM, 0);
        run_command(owb_pkg::OP_RESET, 8'h00, 0, 3, LINE_RANDOM, 0);
        run_command(owb_pkg::OP_RESET, 8'h00, 15, 10, LINE_RANDOM, 0);
    endtask

    task automatic test_byte_writes();
        run_command(owb_pkg::OP_WRITE, 8'h01, 0, 0, LINE_RANDOM, 0);
    endtask

    // Every busy word, the completing one included, carries a command that must be refused.
    // The slave holds the line low past the longest pulse that is measured.
    task automatic test_busy_rejects();
        run_command(owb_pkg::OP_RESET, 8'h00, 0, 400, LINE_RANDOM, 100);
    endtask

    task automatic test_timing_extremes();
        // Zero durations last one microsecond; a zero wait limit ends on the first high
        // sample; a maximum below the minimum never accepts a presence pulse.
        write_timing(make_timing(0, 0, 5, 2, 0, 0));
        run_command(owb_pkg::OP_RESET, 8'h00, 0, 3, LINE_RANDOM, 0);
        run_command(owb_pkg::OP_RESET, 8'h00, 2, 3, LINE_RANDOM, 0);
        run_command(owb_pkg::OP_WRITE, 8'h00, 0, 0, LINE_RANDOM, 0);
    endtask

    // A byte read with no idling while the result side stops for a long stretch, so both
    // internal registers fill and the command side has to stall.
    task automatic test_read_backpressure();
        idling_on    = 1'b0;
        hold_request = HOLD_CYCLES;
        run_command(owb_pkg::OP_READ, 8'h00, 0, 0, LINE_RANDOM, 10);
    endtask

    // Result side: random stall bursts, plus the long hold requested by the pressure test.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_request--;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("result word arrived with nothing expected");
            end else begin
                want = pending_status.pop_front();
                check_field("drive_low", 8'(res_if.drive_low), 8'(want.drive_low));
                check_field("busy", 8'(res_if.busy_res), 8'(want.busy_res));
                check_field("done", 8'(res_if.done_res), 8'(want.done_res));
                check_field("presence", 8'(res_if.presence), 8'(want.presence));
                check_field("read_byte", res_if.read_byte, want.read_byte);
                check_field("rejected", 8'(res_if.rejected), 8'(want.rejected));
                words_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles at %0t", quiet_cycles, $time);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.operation  <= owb_pkg::OP_TICK;
        cmd_if.data_byte  <= '0;
        cmd_if.line_level <= 1'b1;
        cfg_we            <= 1'b0;
        cfg_idx           <= owb_pkg::CFG_RESET_LOW;
        cfg_wdata         <= '0;
        timing.reset_low_time      = owb_pkg::RST_RESET_LOW;
        timing.presence_wait_limit = owb_pkg::RST_PRES_WAIT;
        timing.presence_min        = owb_pkg::RST_PRES_MIN;
        timing.presence_max        = owb_pkg::RST_PRES_MAX;
        timing.write_zero_low      = owb_pkg::RST_WRITE_ZERO;
        timing.read_sample_delay   = owb_pkg::RST_READ_DELAY;
        bus_phase      = owb_pkg::PH_IDLE;
        slot_us        = '0;
        bit_pos        = '0;
        shift_byte     = '0;
        presence_found = 1'b0;
        last_read_byte = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_ticks();
        test_reset_presence();
        test_byte_writes();
        test_busy_rejects();
        test_timing_extremes();
        test_read_backpressure();

        settle_bus();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d command words: %0d resets (%0d presence pulses, %0d timeouts),",
                 words_sent, resets_started, presences, timeouts);
        $display("%0d byte writes, %0d byte reads, %0d refused commands; %0d mismatches.",
                 writes_started, reads_started, rejects, errors);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
